// ===== src/route_table_seqno_update_assert.svh =====
// assertion macros used by the route table storage, rtsu_table
// clocked on clk, disabled while rst_n is low
`ifndef ROUTE_TABLE_SEQNO_UPDATE_ASSERT_SVH
`define ROUTE_TABLE_SEQNO_UPDATE_ASSERT_SVH

// condition implies consequence in the same cycle
`define RTSU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define RTSU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/rtsu_pkg.sv =====
// shared types, widths and status codes of the route table
// no dependencies
package rtsu_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 16;

  localparam int unsigned KEY_W  = 32;
  localparam int unsigned SEQ_W  = 32;
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned PORT_W = 16;
  localparam int unsigned STAT_W = 3;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_NEWER     = 3'd1;
  localparam logic [STAT_W-1:0] ST_SAME      = 3'd2;
  localparam logic [STAT_W-1:0] ST_UNCHANGED = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd4;
  localparam logic [STAT_W-1:0] ST_LOOKUP    = 3'd5;

  // what the table holds for the looked-up key
  typedef struct packed {
    logic              hit;
    logic              has_free;
    logic [SEQ_W-1:0]  seq;
    logic [ADDR_W-1:0] hop_addr;
    logic [PORT_W-1:0] hop_port;
    logic              direct;
  } rtsu_view_t;

  // table write request
  typedef struct packed {
    logic              alloc;
    logic              wr_route;
    logic              wr_seq;
    logic [KEY_W-1:0]  key;
    logic [SEQ_W-1:0]  seq;
    logic [ADDR_W-1:0] hop_addr;
    logic [PORT_W-1:0] hop_port;
    logic              direct;
  } rtsu_wr_t;

  typedef struct packed {
    logic              was_known;
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] hop_addr;
    logic [PORT_W-1:0] hop_port;
    logic              is_direct;
    logic [SEQ_W-1:0]  stored_seq;
  } rtsu_res_t;

endpackage

// ===== src/route_table_seqno_update.sv =====
// top level of the sequence numbered route table
// depends on rtsu_pkg, rtsu_table and rtsu_decide
//
//   channel  direction  ports                                  handshake
//   in       input      in_opcode .. in_sender_port            in_valid / in_stall
//   out      output     out_was_known .. out_stored_seq        out_valid / out_stall
//
// one item per cycle while out_stall is low; each result goes from the input register to the result register
// the table match, decision and write fit between the input and result registers,
// so the next item already sees the entry written by this one
// reset clears the entry valid bits and both stage valid bits, no clearing pass
// out_stall holds the result register; in_stall rises only while both stages are full
// and out_stall is high
module route_table_seqno_update import rtsu_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_opcode,
  input  logic [KEY_W-1:0]  in_origin_key,
  input  logic [SEQ_W-1:0]  in_seq_number,
  input  logic              in_has_shortcut,
  input  logic [ADDR_W-1:0] in_shortcut_addr,
  input  logic [PORT_W-1:0] in_shortcut_port,
  input  logic [ADDR_W-1:0] in_sender_addr,
  input  logic [PORT_W-1:0] in_sender_port,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_was_known,
  output logic [STAT_W-1:0] out_status,
  output logic [ADDR_W-1:0] out_hop_addr,
  output logic [PORT_W-1:0] out_hop_port,
  output logic              out_is_direct,
  output logic [SEQ_W-1:0]  out_stored_seq
);

  logic              in_valid_r;
  logic              opcode_r;
  logic [KEY_W-1:0]  key_r;
  logic [SEQ_W-1:0]  seq_r;
  logic              sc_r;
  logic [ADDR_W-1:0] sc_addr_r;
  logic [PORT_W-1:0] sc_port_r;
  logic [ADDR_W-1:0] snd_addr_r;
  logic [PORT_W-1:0] snd_port_r;

  logic      out_valid_r;
  rtsu_res_t res_r;

  logic       fire;
  rtsu_view_t view;
  rtsu_wr_t   wr;
  rtsu_res_t  res;

  assign fire     = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      opcode_r   <= in_opcode;
      key_r      <= in_origin_key;
      seq_r      <= in_seq_number;
      sc_r       <= in_has_shortcut;
      sc_addr_r  <= in_shortcut_addr;
      sc_port_r  <= in_shortcut_port;
      snd_addr_r <= in_sender_addr;
      snd_port_r <= in_sender_port;
    end
  end

  rtsu_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .look_key (key_r),
    .wr       (wr),
    .view     (view)
  );

  rtsu_decide u_decide (
    .act           (fire),
    .opcode        (opcode_r),
    .origin_key    (key_r),
    .seq_number    (seq_r),
    .has_shortcut  (sc_r),
    .shortcut_addr (sc_addr_r),
    .shortcut_port (sc_port_r),
    .sender_addr   (snd_addr_r),
    .sender_port   (snd_port_r),
    .view          (view),
    .wr            (wr),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_was_known  = res_r.was_known;
  assign out_status     = res_r.status;
  assign out_hop_addr   = res_r.hop_addr;
  assign out_hop_port   = res_r.hop_port;
  assign out_is_direct  = res_r.is_direct;
  assign out_stored_seq = res_r.stored_seq;

endmodule

// ===== src/rtsu_table.sv =====
// route entry storage with parallel key match and lowest free slot search
// depends on rtsu_pkg and route_table_seqno_update_assert.svh
`include "route_table_seqno_update_assert.svh"

module rtsu_table import rtsu_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [KEY_W-1:0] look_key,
  input  rtsu_wr_t         wr,
  output rtsu_view_t       view
);

  logic [TABLE_ENTRIES-1:0] valid_r;
  logic [KEY_W-1:0]         key_r  [TABLE_ENTRIES];
  logic [SEQ_W-1:0]         seq_r  [TABLE_ENTRIES];
  logic [ADDR_W-1:0]        addr_r [TABLE_ENTRIES];
  logic [PORT_W-1:0]        port_r [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] direct_r;

  logic [TABLE_ENTRIES-1:0] match;
  logic [TABLE_ENTRIES-1:0] hit_oh;
  logic [TABLE_ENTRIES-1:0] free;
  logic [TABLE_ENTRIES-1:0] free_oh;
  logic [TABLE_ENTRIES-1:0] wr_oh;

  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      match[i] = valid_r[i] && (key_r[i] == look_key);
    end
  end

  // lowest set bit picks the slot
  assign hit_oh  = match & (~match + 1'b1);
  assign free    = ~valid_r;
  assign free_oh = free & (~free + 1'b1);
  assign wr_oh   = wr.alloc ? free_oh : hit_oh;

  always_comb begin
    view          = '0;
    view.hit      = |match;
    view.has_free = |free;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (hit_oh[i]) begin
        view.seq      = view.seq | seq_r[i];
        view.hop_addr = view.hop_addr | addr_r[i];
        view.hop_port = view.hop_port | port_r[i];
        view.direct   = view.direct | direct_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.alloc) begin
      valid_r <= valid_r | free_oh;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (wr_oh[i]) begin
        if (wr.alloc) begin
          key_r[i] <= wr.key;
        end
        if (wr.wr_seq) begin
          seq_r[i] <= wr.seq;
        end
        if (wr.wr_route) begin
          addr_r[i]   <= wr.hop_addr;
          port_r[i]   <= wr.hop_port;
          direct_r[i] <= wr.direct;
        end
      end
    end
  end

  `RTSU_ASSERT_NOW(a_alloc_only_on_miss, wr.alloc, !view.hit && view.has_free,
    "slot allocated for a known key or a full table")
  `RTSU_ASSERT_NOW(a_update_needs_entry, (wr.wr_route || wr.wr_seq) && !wr.alloc,
    view.hit, "route update without a matching entry")
  `RTSU_ASSERT_NEXT(a_alloc_grows, wr.alloc,
    $countones(valid_r) == $past($countones(valid_r)) + 1,
    "allocation did not add exactly one entry")
  `RTSU_ASSERT_NEXT(a_no_removal, !wr.alloc,
    valid_r == $past(valid_r), "valid bits changed without allocation")

endmodule

// ===== src/rtsu_decide.sv =====
// update and lookup decision for one item against the matched entry
// depends on rtsu_pkg
module rtsu_decide import rtsu_pkg::*; (
  input  logic              act,
  input  logic              opcode,
  input  logic [KEY_W-1:0]  origin_key,
  input  logic [SEQ_W-1:0]  seq_number,
  input  logic              has_shortcut,
  input  logic [ADDR_W-1:0] shortcut_addr,
  input  logic [PORT_W-1:0] shortcut_port,
  input  logic [ADDR_W-1:0] sender_addr,
  input  logic [PORT_W-1:0] sender_port,
  input  rtsu_view_t        view,
  output rtsu_wr_t          wr,
  output rtsu_res_t         res
);

  logic newer;
  logic same;
  logic alloc;
  logic wr_route;
  logic wr_seq;

  assign newer = view.seq < seq_number;
  assign same  = view.seq == seq_number;

  always_comb begin
    alloc    = 1'b0;
    wr_route = 1'b0;
    wr_seq   = 1'b0;
    res      = '0;
    if (opcode == OP_LOOKUP) begin
      res.was_known = view.hit;
      res.status    = ST_LOOKUP;
    end else if (!view.hit) begin
      if (view.has_free) begin
        alloc      = 1'b1;
        wr_route   = 1'b1;
        wr_seq     = 1'b1;
        res.status = ST_INSERTED;
      end else begin
        res.status = ST_FULL;
      end
    end else begin
      res.was_known = 1'b1;
      if (newer) begin
        wr_route   = 1'b1;
        wr_seq     = 1'b1;
        res.status = ST_NEWER;
      end else if (same && !(has_shortcut && view.direct)) begin
        wr_route   = 1'b1;
        res.status = ST_SAME;
      end else begin
        res.status = ST_UNCHANGED;
      end
    end

    wr.alloc    = act && alloc;
    wr.wr_route = act && wr_route;
    wr.wr_seq   = act && wr_seq;
    wr.key      = origin_key;
    wr.seq      = seq_number;
    wr.hop_addr = has_shortcut ? shortcut_addr : sender_addr;
    wr.hop_port = has_shortcut ? shortcut_port : sender_port;
    wr.direct   = !has_shortcut;

    // report what the entry holds after this item
    if (view.hit || alloc) begin
      res.hop_addr   = wr_route ? wr.hop_addr : view.hop_addr;
      res.hop_port   = wr_route ? wr.hop_port : view.hop_port;
      res.is_direct  = wr_route ? wr.direct : view.direct;
      res.stored_seq = wr_seq ? seq_number : view.seq;
    end
  end

endmodule

// ===== tb/route_table_seqno_update_tb.sv =====
// self-checking testbench of the sequence numbered route table
// depends on rtsu_pkg and route_table_seqno_update; keeps its own copy of the table
// empty table, update rules, overflow, then random traffic with and without stalls
module route_table_seqno_update_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rtsu_pkg::*;

  localparam int NUM_SLOTS   = TABLE_ENTRIES_DEF;
  localparam int IDLE_LIMIT  = 1000;
  localparam int RANDOM_MSGS = 470;
  localparam int FINAL_MSGS  = 50;

  typedef struct {
    logic              op;
    logic [KEY_W-1:0]  key;
    logic [SEQ_W-1:0]  seq;
    logic              sc;
    logic [ADDR_W-1:0] sc_addr;
    logic [PORT_W-1:0] sc_port;
    logic [ADDR_W-1:0] snd_addr;
    logic [PORT_W-1:0] snd_port;
  } route_msg_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic              in_opcode;
  logic [KEY_W-1:0]  in_origin_key;
  logic [SEQ_W-1:0]  in_seq_number;
  logic              in_has_shortcut;
  logic [ADDR_W-1:0] in_shortcut_addr;
  logic [PORT_W-1:0] in_shortcut_port;
  logic [ADDR_W-1:0] in_sender_addr;
  logic [PORT_W-1:0] in_sender_port;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_was_known;
  logic [STAT_W-1:0] out_status;
  logic [ADDR_W-1:0] out_hop_addr;
  logic [PORT_W-1:0] out_hop_port;
  logic              out_is_direct;
  logic [SEQ_W-1:0]  out_stored_seq;

  // table copy
  logic              route_valid [NUM_SLOTS];
  logic [KEY_W-1:0]  route_key   [NUM_SLOTS];
  logic [SEQ_W-1:0]  route_seq   [NUM_SLOTS];
  logic [ADDR_W-1:0] route_addr  [NUM_SLOTS];
  logic [PORT_W-1:0] route_port  [NUM_SLOTS];
  logic              route_direct[NUM_SLOTS];

  logic [KEY_W-1:0] key_pool[NUM_SLOTS];
  rtsu_res_t        pending_results[$];
  rtsu_res_t        want;
  logic             idle_on = 1'b0;
  int               stall_left = 0;
  int               stuck_cycles = 0;
  int               mismatch_count = 0;
  int               checked_count = 0;
  int               sent_count = 0;
  int               status_seen[8];

  route_table_seqno_update DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_origin_key    (in_origin_key),
    .in_seq_number    (in_seq_number),
    .in_has_shortcut  (in_has_shortcut),
    .in_shortcut_addr (in_shortcut_addr),
    .in_shortcut_port (in_shortcut_port),
    .in_sender_addr   (in_sender_addr),
    .in_sender_port   (in_sender_port),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_was_known    (out_was_known),
    .out_status       (out_status),
    .out_hop_addr     (out_hop_addr),
    .out_hop_port     (out_hop_port),
    .out_is_direct    (out_is_direct),
    .out_stored_seq   (out_stored_seq)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int find_route(logic [KEY_W-1:0] key);
    for (int i = 0; i < NUM_SLOTS; i++)
      if (route_valid[i] && route_key[i] == key) return i;
    return -1;
  endfunction

  function automatic void store_hop(int slot, route_msg_t m);
    if (m.sc) begin
      route_addr[slot]   = m.sc_addr;
      route_port[slot]   = m.sc_port;
      route_direct[slot] = 1'b0;
    end else begin
      route_addr[slot]   = m.snd_addr;
      route_port[slot]   = m.snd_port;
      route_direct[slot] = 1'b1;
    end
  endfunction

  function automatic rtsu_res_t predict_route(route_msg_t m);
    rtsu_res_t res;
    int slot;
    res = '0;
    slot = find_route(m.key);
    res.was_known = (slot >= 0);
    if (m.op == OP_LOOKUP) begin
      res.status = ST_LOOKUP;
    end else if (slot < 0) begin
      for (int i = NUM_SLOTS - 1; i >= 0; i--)
        if (!route_valid[i]) slot = i;
      if (slot < 0) begin
        res.status = ST_FULL;
      end else begin
        route_valid[slot] = 1'b1;
        route_key[slot]   = m.key;
        route_seq[slot]   = m.seq;
        store_hop(slot, m);
        res.status = ST_INSERTED;
      end
    end else if (route_seq[slot] < m.seq) begin
      store_hop(slot, m);
      route_seq[slot] = m.seq;
      res.status = ST_NEWER;
    end else if (route_seq[slot] == m.seq && (!m.sc || !route_direct[slot])) begin
      store_hop(slot, m);
      res.status = ST_SAME;
    end else begin
      res.status = ST_UNCHANGED;
    end
    if (slot >= 0) begin
      res.hop_addr   = route_addr[slot];
      res.hop_port   = route_port[slot];
      res.is_direct  = route_direct[slot];
      res.stored_seq = route_seq[slot];
    end
    return res;
  endfunction

  function automatic route_msg_t rand_msg();
    route_msg_t m;
    m.op       = OP_UPDATE;
    m.key      = $urandom;
    m.seq      = $urandom;
    m.sc       = 1'($urandom_range(0, 1));
    m.sc_addr  = $urandom;
    m.sc_port  = 16'($urandom);
    m.snd_addr = $urandom;
    m.snd_port = 16'($urandom);
    return m;
  endfunction

  function automatic logic [KEY_W-1:0] fresh_key();
    logic [KEY_W-1:0] k;
    do k = $urandom; while (find_route(k) >= 0);
    return k;
  endfunction

  task automatic send_msg(input route_msg_t m);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_opcode        <= m.op;
    in_origin_key    <= m.key;
    in_seq_number    <= m.seq;
    in_has_shortcut  <= m.sc;
    in_shortcut_addr <= m.sc_addr;
    in_shortcut_port <= m.sc_port;
    in_sender_addr   <= m.snd_addr;
    in_sender_port   <= m.snd_port;
    in_valid         <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_route(m));
    sent_count++;
  endtask

  task automatic send_update(logic [KEY_W-1:0] key, logic [SEQ_W-1:0] seq, logic sc);
    route_msg_t m;
    m = rand_msg();
    m.key = key;
    m.seq = seq;
    m.sc  = sc;
    send_msg(m);
  endtask

  task automatic send_lookup(logic [KEY_W-1:0] key);
    route_msg_t m;
    m = rand_msg();
    m.op  = OP_LOOKUP;
    m.key = key;
    send_msg(m);
  endtask

  task automatic wait_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic test_empty_table();
    route_msg_t m;
    send_lookup('0);
    m = rand_msg();
    m.key = '0;
    m.seq = '0;
    m.sc = 1'b0;
    m.sc_addr = '0;
    m.sc_port = '0;
    m.snd_addr = '1;
    m.snd_port = '1;
    send_msg(m);
    m = rand_msg();
    m.key = '1;
    m.seq = '1;
    m.sc = 1'b1;
    m.sc_addr = '1;
    m.sc_port = '1;
    m.snd_addr = '0;
    m.snd_port = '0;
    send_msg(m);
    send_lookup('1);
    wait_results();
  endtask

  task automatic test_seq_rules();
    send_update('0, 32'd5, 1'b1);
    send_update('0, 32'd5, 1'b1);
    send_update('0, 32'd5, 1'b0);
    send_update('0, 32'd5, 1'b1);
    send_update('0, 32'd4, 1'b0);
    send_update('0, '1, 1'b0);
    send_update('1, '0, 1'b0);
    send_update('1, '1, 1'b0);
    send_update('1, '1, 1'b1);
    send_lookup('0);
    wait_results();
  endtask

  task automatic test_table_full();
    key_pool[0] = '0;
    key_pool[1] = '1;
    key_pool[2] = 32'h0000_0001;
    key_pool[3] = 32'h8000_0000;
    for (int i = 4; i < NUM_SLOTS; i++) key_pool[i] = fresh_key();
    for (int i = 2; i < NUM_SLOTS; i++)
      send_update(key_pool[i], $urandom, 1'($urandom_range(0, 1)));
    send_update(fresh_key(), $urandom, 1'b1);
    send_lookup(fresh_key());
    wait_results();
  endtask

  task automatic test_random_mix(int count);
    route_msg_t m;
    int slot;
    for (int i = 0; i < count; i++) begin
      // sender holds off until the table has answered everything
      if (i % 120 == 119) wait_results();
      idle_on = ((i / 80) % 4 != 3);
      m = rand_msg();
      m.key = ($urandom_range(0, 9) == 0) ? fresh_key()
                                          : key_pool[$urandom_range(0, NUM_SLOTS - 1)];
      if ($urandom_range(0, 9) == 0) m.op = OP_LOOKUP;
      slot = find_route(m.key);
      if (slot >= 0) begin
        case ($urandom_range(0, 4))
          0: m.seq = route_seq[slot] + $urandom_range(1, 3);
          1, 2: m.seq = route_seq[slot];
          3: m.seq = route_seq[slot] - $urandom_range(1, 3);
          default: ;
        endcase
      end
      send_msg(m);
    end
    wait_results();
  endtask

  task automatic test_back_to_back(int count);
    route_msg_t m;
    int slot;
    idle_on = 1'b0;
    for (int i = 0; i < count; i++) begin
      m = rand_msg();
      m.key = key_pool[$urandom_range(0, 3)];
      if ($urandom_range(0, 7) == 0) m.op = OP_LOOKUP;
      slot = find_route(m.key);
      m.seq = route_seq[slot] + $urandom_range(0, 1);
      send_msg(m);
    end
  endtask

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, got_v);
      mismatch_count++;
    end
  endfunction

  always @(negedge clk) begin
    if (!idle_on) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 13);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no expected result pending");
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("was_known", 32'(want.was_known), 32'(out_was_known));
        check_field("status", 32'(want.status), 32'(out_status));
        check_field("hop_addr", want.hop_addr, out_hop_addr);
        check_field("hop_port", 32'(want.hop_port), 32'(out_hop_port));
        check_field("is_direct", 32'(want.is_direct), 32'(out_is_direct));
        check_field("stored_seq", want.stored_seq, out_stored_seq);
        status_seen[out_status]++;
        checked_count++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= IDLE_LIMIT) begin
        $display("route_table_seqno_update_tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_opcode        = OP_UPDATE;
    in_origin_key    = '0;
    in_seq_number    = '0;
    in_has_shortcut  = 1'b0;
    in_shortcut_addr = '0;
    in_shortcut_port = '0;
    in_sender_addr   = '0;
    in_sender_port   = '0;
    for (int i = 0; i < NUM_SLOTS; i++) route_valid[i] = 1'b0;
    for (int i = 0; i < 8; i++) status_seen[i] = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    idle_on = 1'b1;
    test_empty_table();
    test_seq_rules();
    test_table_full();
    test_random_mix(RANDOM_MSGS);
    test_back_to_back(FINAL_MSGS);
    wait_results();
    repeat (6) @(posedge clk);
    $display("%0d transfers in, %0d results checked, %0d mismatches", sent_count,
             checked_count, mismatch_count);
    $display("outcomes: inserted %0d, newer %0d, same seq %0d, unchanged %0d",
             status_seen[ST_INSERTED], status_seen[ST_NEWER], status_seen[ST_SAME],
             status_seen[ST_UNCHANGED]);
    $display("          full %0d, lookup %0d", status_seen[ST_FULL], status_seen[ST_LOOKUP]);
    if (mismatch_count == 0) begin
      $display("route_table_seqno_update_tb OK");
    end else begin
      $display("route_table_seqno_update_tb NOT OK");
    end
    $finish;
  end

endmodule
